// ===== design/ltd_pkg.sv =====
// ----------------------------------------------------------------------------
// ltd_pkg
// Shared widths, register map, level codes and control types of the lateral
// tremor detector.
// ----------------------------------------------------------------------------
package ltd_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int FRAC_BITS   = 8;

  localparam int FW  = SAMPLE_BITS + FRAC_BITS;
  localparam int DW  = FW + 1;
  localparam int WW  = FRAC_BITS + 1;
  localparam int PW  = DW + WW + 1;
  localparam int SW  = PW - FRAC_BITS;
  localparam int NW  = SW + 1;
  localparam int AW  = DW - 1;
  localparam int QW  = 2 * AW;

  localparam int THR_W    = 16;
  localparam int THR_SQ_W = 2 * THR_W;
  localparam int LEVEL_W  = 2;
  localparam int ENERGY_W = 37;
  localparam int ESUM_W   = (QW + 1 > ENERGY_W) ? QW + 1 : ENERGY_W;

  localparam int DATA_W = 32;
  localparam int ADDR_W = 5;
  localparam int IDX_W  = 3;

  localparam logic [WW-1:0]    WEIGHT_ONE       = WW'(1 << FRAC_BITS);
  localparam logic [WW-1:0]    RST_WEIGHT       = WW'(51);
  localparam logic [THR_W-1:0] RST_THR_MILD     = THR_W'(655);
  localparam logic [THR_W-1:0] RST_THR_STRONG   = THR_W'(1966);
  localparam logic [THR_W-1:0] RST_THR_STR_END  = THR_W'(3277);
  localparam logic [THR_W-1:0] RST_THR_ALERT    = THR_W'(32768);

  typedef enum logic [IDX_W-1:0] {
    REG_SMOOTH_WEIGHT  = 3'd0,
    REG_THR_MILD       = 3'd1,
    REG_THR_STRONG     = 3'd2,
    REG_THR_STRONG_END = 3'd3,
    REG_THR_ALERT      = 3'd4
  } reg_idx_t;

  typedef enum logic [LEVEL_W-1:0] {
    LVL_NONE   = 2'd0,
    LVL_MILD   = 2'd1,
    LVL_STRONG = 2'd2,
    LVL_ALERT  = 2'd3
  } level_t;

  typedef struct packed {
    logic [WW-1:0]    smooth_weight;
    logic [THR_W-1:0] thr_mild;
    logic [THR_W-1:0] thr_strong;
    logic [THR_W-1:0] thr_strong_end;
    logic [THR_W-1:0] thr_alert;
  } cfg_t;

  typedef struct packed {
    logic mul;
    logic upd;
    logic sq;
    logic fin;
  } cmd_t;

endpackage

// ===== design/ltd_sample_if.sv =====
// ----------------------------------------------------------------------------
// ltd_sample_if
// Input channel: one X/Y accelerometer sample per item.
// ----------------------------------------------------------------------------
interface ltd_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ltd_pkg::SAMPLE_BITS-1:0] raw_x;
  logic signed [ltd_pkg::SAMPLE_BITS-1:0] raw_y;

  modport source (output valid, output raw_x, output raw_y, input ready);
  modport sink   (input valid, input raw_x, input raw_y, output ready);
endinterface

// ===== design/ltd_result_if.sv =====
// ----------------------------------------------------------------------------
// ltd_result_if
// Output channel: tremor level and lateral energy per item.
// ----------------------------------------------------------------------------
interface ltd_result_if;
  logic                            valid;
  logic                            ready;
  logic [ltd_pkg::LEVEL_W-1:0]     tremor_level;
  logic [ltd_pkg::ENERGY_W-1:0]    lateral_energy;

  modport source (output valid, output tremor_level, output lateral_energy, input ready);
  modport sink   (input valid, input tremor_level, input lateral_energy, output ready);
endinterface

// ===== design/ltd_cfg.sv =====
// ----------------------------------------------------------------------------
// ltd_cfg
// APB register bank: filter weight and the four magnitude thresholds.
// ----------------------------------------------------------------------------
module ltd_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ltd_pkg::ADDR_W-1:0]   paddr,
  input  logic [ltd_pkg::DATA_W-1:0]   pwdata,
  output logic [ltd_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output ltd_pkg::cfg_t                cfg
);

  ltd_pkg::reg_idx_t idx;
  logic              wr;

  assign idx    = ltd_pkg::reg_idx_t'(paddr[ltd_pkg::ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.smooth_weight  <= ltd_pkg::RST_WEIGHT;
      cfg.thr_mild       <= ltd_pkg::RST_THR_MILD;
      cfg.thr_strong     <= ltd_pkg::RST_THR_STRONG;
      cfg.thr_strong_end <= ltd_pkg::RST_THR_STR_END;
      cfg.thr_alert      <= ltd_pkg::RST_THR_ALERT;
    end else if (wr) begin
      case (idx)
        ltd_pkg::REG_SMOOTH_WEIGHT:  cfg.smooth_weight  <= pwdata[ltd_pkg::WW-1:0];
        ltd_pkg::REG_THR_MILD:       cfg.thr_mild       <= pwdata[ltd_pkg::THR_W-1:0];
        ltd_pkg::REG_THR_STRONG:     cfg.thr_strong     <= pwdata[ltd_pkg::THR_W-1:0];
        ltd_pkg::REG_THR_STRONG_END: cfg.thr_strong_end <= pwdata[ltd_pkg::THR_W-1:0];
        ltd_pkg::REG_THR_ALERT:      cfg.thr_alert      <= pwdata[ltd_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      ltd_pkg::REG_SMOOTH_WEIGHT:  prdata = ltd_pkg::DATA_W'(cfg.smooth_weight);
      ltd_pkg::REG_THR_MILD:       prdata = ltd_pkg::DATA_W'(cfg.thr_mild);
      ltd_pkg::REG_THR_STRONG:     prdata = ltd_pkg::DATA_W'(cfg.thr_strong);
      ltd_pkg::REG_THR_STRONG_END: prdata = ltd_pkg::DATA_W'(cfg.thr_strong_end);
      ltd_pkg::REG_THR_ALERT:      prdata = ltd_pkg::DATA_W'(cfg.thr_alert);
      default:                     prdata = '0;
    endcase
  end

endmodule

// ===== design/ltd_ctrl.sv =====
// ----------------------------------------------------------------------------
// ltd_ctrl
// Sequencer: steps one item through multiply, update, square and finish,
// and owns the result valid flag.
// ----------------------------------------------------------------------------
module ltd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output ltd_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPD,
    ST_SQ,
    ST_FIN
  } state_t;

  state_t state;
  logic   out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd.mul = (state == ST_IDLE) && in_valid;
    cmd.upd = (state == ST_UPD);
    cmd.sq  = (state == ST_SQ);
    cmd.fin = (state == ST_FIN) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: if (in_valid) state <= ST_UPD;
        ST_UPD:  state <= ST_SQ;
        ST_SQ:   state <= ST_FIN;
        ST_FIN:  if (out_free) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
      if (cmd.fin) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/ltd_dp.sv =====
// ----------------------------------------------------------------------------
// ltd_dp
// Datapath: per-axis low-pass filter, change of filtered value, squared
// lateral energy and level decision.
// ----------------------------------------------------------------------------
module ltd_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  ltd_pkg::cmd_t                          cmd,
  input  ltd_pkg::cfg_t                          cfg,
  input  logic signed [ltd_pkg::SAMPLE_BITS-1:0] raw_x,
  input  logic signed [ltd_pkg::SAMPLE_BITS-1:0] raw_y,
  output logic [ltd_pkg::LEVEL_W-1:0]            tremor_level,
  output logic [ltd_pkg::ENERGY_W-1:0]           lateral_energy
);

  localparam int FW = ltd_pkg::FW;
  localparam int DW = ltd_pkg::DW;
  localparam int WW = ltd_pkg::WW;
  localparam int PW = ltd_pkg::PW;
  localparam int SW = ltd_pkg::SW;
  localparam int NW = ltd_pkg::NW;
  localparam int AW = ltd_pkg::AW;
  localparam int QW = ltd_pkg::QW;
  localparam int EW = ltd_pkg::ENERGY_W;
  localparam int XW = ltd_pkg::ESUM_W;
  localparam int TW = ltd_pkg::THR_SQ_W;

  localparam logic signed [FW-1:0] F_LO = {1'b1, {(FW-1){1'b0}}};
  localparam logic signed [FW-1:0] F_HI =
    {1'b0, {(ltd_pkg::SAMPLE_BITS-1){1'b1}}, {ltd_pkg::FRAC_BITS{1'b0}}};
  localparam logic [XW-1:0] E_MAX = XW'({EW{1'b1}});

  logic signed [FW-1:0] filt_x;
  logic signed [FW-1:0] filt_y;
  logic signed [PW-1:0] prod_x;
  logic signed [PW-1:0] prod_y;
  logic [AW-1:0]        mag_x;
  logic [AW-1:0]        mag_y;
  logic [QW-1:0]        sq_x;
  logic [QW-1:0]        sq_y;
  logic [TW-1:0]        m2;
  logic [TW-1:0]        s2;
  logic [TW-1:0]        se2;
  logic [TW-1:0]        a2;

  logic [WW-1:0]        w_eff;
  logic signed [WW:0]   w_s;
  logic signed [DW-1:0] diff_x;
  logic signed [DW-1:0] diff_y;
  logic signed [FW-1:0] nf_x;
  logic signed [FW-1:0] nf_y;
  logic [AW-1:0]        dmag_x;
  logic [AW-1:0]        dmag_y;
  logic [XW-1:0]        esum;
  logic [EW-1:0]        energy;
  logic [EW-1:0]        m2_e;
  logic [EW-1:0]        s2_e;
  logic [EW-1:0]        se2_e;
  logic [EW-1:0]        a2_e;
  ltd_pkg::level_t      level;

  function automatic logic signed [DW-1:0] sample_diff(
    input logic signed [ltd_pkg::SAMPLE_BITS-1:0] x,
    input logic signed [FW-1:0]                   f
  );
    logic signed [FW-1:0] xs;
    xs = $signed({x, {ltd_pkg::FRAC_BITS{1'b0}}});
    return DW'(xs) - DW'(f);
  endfunction

  function automatic logic signed [FW-1:0] filt_next(
    input logic signed [FW-1:0] f,
    input logic signed [PW-1:0] p
  );
    logic signed [SW-1:0] stp;
    logic signed [NW-1:0] sum;
    stp = SW'(p >>> ltd_pkg::FRAC_BITS);
    sum = NW'(f) + NW'(stp);
    if (sum < NW'(F_LO)) begin
      return F_LO;
    end else if (sum > NW'(F_HI)) begin
      return F_HI;
    end
    return FW'(sum);
  endfunction

  function automatic logic [AW-1:0] change_mag(
    input logic signed [FW-1:0] nf,
    input logic signed [FW-1:0] f
  );
    logic signed [DW-1:0] d;
    d = DW'(nf) - DW'(f);
    return (d < 0) ? AW'(-d) : AW'(d);
  endfunction

  assign w_eff  = (cfg.smooth_weight > ltd_pkg::WEIGHT_ONE) ? ltd_pkg::WEIGHT_ONE
                                                            : cfg.smooth_weight;
  assign w_s    = $signed({1'b0, w_eff});
  assign diff_x = sample_diff(raw_x, filt_x);
  assign diff_y = sample_diff(raw_y, filt_y);
  assign nf_x   = filt_next(filt_x, prod_x);
  assign nf_y   = filt_next(filt_y, prod_y);
  assign dmag_x = change_mag(nf_x, filt_x);
  assign dmag_y = change_mag(nf_y, filt_y);

  assign esum   = XW'(sq_x) + XW'(sq_y);
  assign energy = (esum > E_MAX) ? {EW{1'b1}} : EW'(esum);
  assign m2_e   = EW'(m2);
  assign s2_e   = EW'(s2);
  assign se2_e  = EW'(se2);
  assign a2_e   = EW'(a2);

  always_comb begin
    if (energy > m2_e && energy < s2_e) begin
      level = ltd_pkg::LVL_MILD;
    end else if (energy >= s2_e && energy < se2_e) begin
      level = ltd_pkg::LVL_STRONG;
    end else if (energy >= a2_e) begin
      level = ltd_pkg::LVL_ALERT;
    end else begin
      level = ltd_pkg::LVL_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filt_x <= '0;
      filt_y <= '0;
    end else if (cmd.upd) begin
      filt_x <= nf_x;
      filt_y <= nf_y;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_x <= w_s * diff_x;
      prod_y <= w_s * diff_y;
    end
    if (cmd.upd) begin
      mag_x <= dmag_x;
      mag_y <= dmag_y;
    end
    if (cmd.sq) begin
      sq_x <= mag_x * mag_x;
      sq_y <= mag_y * mag_y;
      m2   <= cfg.thr_mild * cfg.thr_mild;
      s2   <= cfg.thr_strong * cfg.thr_strong;
      se2  <= cfg.thr_strong_end * cfg.thr_strong_end;
      a2   <= cfg.thr_alert * cfg.thr_alert;
    end
    if (cmd.fin) begin
      tremor_level   <= level;
      lateral_energy <= energy;
    end
  end

endmodule

// ===== design/lateral_tremor_detector_unit.sv =====
// ----------------------------------------------------------------------------
// lateral_tremor_detector_unit
// Lateral tremor detector: filters X/Y samples, squares the change of the
// filtered values and grades the energy against four thresholds.
// ----------------------------------------------------------------------------
// Sequence: an item is multiplied as it is accepted in idle, then passes the
//   update, square and finish steps; result valid is set as finish ends, and
//   finish waits while a result is unread; a new item is taken only in idle.
// Reset: synchronous rst clears filter state, sequencer and result valid, and
//   loads the register defaults; no clearing pass.
module lateral_tremor_detector_unit (
  input  logic                       clk,
  input  logic                       rst,
  ltd_sample_if.sink                 sample,
  ltd_result_if.source               result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ltd_pkg::ADDR_W-1:0] paddr,
  input  logic [ltd_pkg::DATA_W-1:0] pwdata,
  output logic [ltd_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  ltd_pkg::cfg_t cfg;
  ltd_pkg::cmd_t cmd;

  ltd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ltd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd)
  );

  ltd_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg            (cfg),
    .raw_x          (sample.raw_x),
    .raw_y          (sample.raw_y),
    .tremor_level   (result.tremor_level),
    .lateral_energy (result.lateral_energy)
  );

endmodule

// ===== design/ltd_checker.sv =====
// ----------------------------------------------------------------------------
// ltd_checker
// Port-level checks of the lateral tremor detector, bound to the top level.
// ----------------------------------------------------------------------------
module ltd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_valid,
  input logic                          s_ready,
  input logic                          r_valid,
  input logic                          r_ready,
  input logic [ltd_pkg::LEVEL_W-1:0]   r_level,
  input logic [ltd_pkg::ENERGY_W-1:0]  r_energy
);

  a_reset_clears_result: assert property (@(posedge clk)
    rst |=> !r_valid)
    else $error("result valid after reset");

  a_result_holds: assert property (@(posedge clk)
    !rst && r_valid && !r_ready |=> r_valid)
    else $error("result dropped while stalled");

  a_result_stable: assert property (@(posedge clk)
    !rst && r_valid && !r_ready |=> $stable(r_level) && $stable(r_energy))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk)
    !rst && s_valid && s_ready |=> !s_ready)
    else $error("input ready right after an accepted item");

  a_mild_has_energy: assert property (@(posedge clk)
    r_valid && r_level == ltd_pkg::LVL_MILD |-> r_energy != '0)
    else $error("mild level with zero energy");

endmodule

bind lateral_tremor_detector_unit ltd_checker u_ltd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_valid  (sample.valid),
  .s_ready  (sample.ready),
  .r_valid  (result.valid),
  .r_ready  (result.ready),
  .r_level  (result.tremor_level),
  .r_energy (result.lateral_energy)
);

// ===== test/ltd_tremor_checker.sv =====
// ----------------------------------------------------------------------------
// ltd_tremor_checker
// Watches the register port and both item channels of the lateral tremor
// detector. Keeps its own copy of the filter state and the thresholds,
// works out the tremor level and lateral energy of every accepted sample
// item, and compares each result item, field by field, with the oldest one
// still waiting.
// ----------------------------------------------------------------------------
module ltd_tremor_checker (
  input  logic                       clk,
  input  logic                       rst,
  ltd_sample_if                      smp,
  ltd_result_if                      res,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ltd_pkg::ADDR_W-1:0] paddr,
  input  logic [ltd_pkg::DATA_W-1:0] pwdata,
  input  logic                       pready,
  output int                         outstanding,
  output int                         mismatches
);
  timeunit 1ns;
  timeprecision 1ps;
  import ltd_pkg::*;

  typedef struct packed {
    level_t              level;
    logic [ENERGY_W-1:0] energy;
  } tremor_grade_t;

  localparam longint ENERGY_CEIL = (longint'(1) << ENERGY_W) - 1;
  localparam longint FILT_LO     = -(longint'(1) << (SAMPLE_BITS - 1)) << FRAC_BITS;
  localparam longint FILT_HI     = ((longint'(1) << (SAMPLE_BITS - 1)) - 1) << FRAC_BITS;

  logic [WW-1:0]        weight;
  logic [THR_W-1:0]     thr_mild;
  logic [THR_W-1:0]     thr_strong;
  logic [THR_W-1:0]     thr_strong_end;
  logic [THR_W-1:0]     thr_alert;
  logic signed [FW-1:0] filt_x;
  logic signed [FW-1:0] filt_y;
  tremor_grade_t        pending_grades[$];
  int                   err_cnt = 0;

  assign mismatches = err_cnt;

  function automatic logic signed [FW-1:0] smooth_axis(input logic signed [FW-1:0] f,
                                                       input logic signed [SAMPLE_BITS-1:0] x,
                                                       output longint delta);
    longint w;
    longint d;
    longint nf;
    w  = (weight > WEIGHT_ONE) ? longint'(WEIGHT_ONE) : longint'(weight);
    d  = (longint'(x) <<< FRAC_BITS) - longint'(f);
    nf = longint'(f) + ((w * d) >>> FRAC_BITS);
    if (nf < FILT_LO) nf = FILT_LO;
    if (nf > FILT_HI) nf = FILT_HI;
    delta = nf - longint'(f);
    return FW'(nf);
  endfunction

  function automatic tremor_grade_t grade_sample(input logic signed [SAMPLE_BITS-1:0] x,
                                                 input logic signed [SAMPLE_BITS-1:0] y);
    longint        dx;
    longint        dy;
    longint        e;
    longint        m2;
    longint        s2;
    longint        se2;
    longint        a2;
    tremor_grade_t g;
    filt_x = smooth_axis(filt_x, x, dx);
    filt_y = smooth_axis(filt_y, y, dy);
    e = dx * dx + dy * dy;
    if (e > ENERGY_CEIL) e = ENERGY_CEIL;
    m2  = longint'(thr_mild) * longint'(thr_mild);
    s2  = longint'(thr_strong) * longint'(thr_strong);
    se2 = longint'(thr_strong_end) * longint'(thr_strong_end);
    a2  = longint'(thr_alert) * longint'(thr_alert);
    if (e > m2 && e < s2) g.level = LVL_MILD;
    else if (e >= s2 && e < se2) g.level = LVL_STRONG;
    else if (e >= a2) g.level = LVL_ALERT;
    else g.level = LVL_NONE;
    g.energy = ENERGY_W'(e);
    return g;
  endfunction

  always @(posedge clk) begin
    tremor_grade_t want;
    if (rst) begin
      weight         = RST_WEIGHT;
      thr_mild       = RST_THR_MILD;
      thr_strong     = RST_THR_STRONG;
      thr_strong_end = RST_THR_STR_END;
      thr_alert      = RST_THR_ALERT;
      filt_x         = '0;
      filt_y         = '0;
      pending_grades.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_SMOOTH_WEIGHT:  weight         = pwdata[WW-1:0];
          REG_THR_MILD:       thr_mild       = pwdata[THR_W-1:0];
          REG_THR_STRONG:     thr_strong     = pwdata[THR_W-1:0];
          REG_THR_STRONG_END: thr_strong_end = pwdata[THR_W-1:0];
          REG_THR_ALERT:      thr_alert      = pwdata[THR_W-1:0];
          default: ;
        endcase
      end
      if (res.valid && res.ready) begin
        if (pending_grades.size() == 0) begin
          $error("result item with none expected: tremor_level %0d, lateral_energy %0d",
                 res.tremor_level, res.lateral_energy);
          err_cnt++;
        end else begin
          want = pending_grades.pop_front();
          if (res.tremor_level !== want.level) begin
            $error("tremor_level: expected %0d, actual %0d", want.level, res.tremor_level);
            err_cnt++;
          end
          if (res.lateral_energy !== want.energy) begin
            $error("lateral_energy: expected %0d, actual %0d", want.energy,
                   res.lateral_energy);
            err_cnt++;
          end
        end
      end
      if (smp.valid && smp.ready) pending_grades.push_back(grade_sample(smp.raw_x, smp.raw_y));
    end
    outstanding <= pending_grades.size();
  end

endmodule

// ===== test/tb_lateral_tremor_detector_unit.sv =====
// ----------------------------------------------------------------------------
// tb_lateral_tremor_detector_unit
// Drives X/Y sample items and register writes into the lateral tremor
// detector: a short directed run at the field extremes and at each level,
// then random samples under many register settings, with random idle bursts
// on both channels and a quiet stretch at the end. The checker beside the
// block predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_lateral_tremor_detector_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import ltd_pkg::*;

  localparam int               RESULT_LATENCY = 4;
  localparam int               CYCLE_LIMIT    = 300000;
  localparam logic [IDX_W-1:0] REG_UNMAPPED   = IDX_W'(5);

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                outstanding;
  int                mismatches;
  int                cycle_count = 0;
  bit                steady = 1'b0;
  int                walk_x = 0;
  int                walk_y = 0;

  ltd_sample_if sample_ch ();
  ltd_result_if result_ch ();

  lateral_tremor_detector_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ltd_tremor_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .smp         (sample_ch),
    .res         (result_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[lateral_tremor_detector_unit] ERROR");
      $finish;
    end
  end

  initial begin
    result_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (steady) begin
        result_ch.ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 4) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_config(input logic [WW-1:0] w, input logic [THR_W-1:0] m,
                             input logic [THR_W-1:0] s, input logic [THR_W-1:0] se,
                             input logic [THR_W-1:0] a);
    write_reg(REG_SMOOTH_WEIGHT, {23'($urandom), w});
    write_reg(REG_THR_MILD, {16'($urandom), m});
    write_reg(REG_THR_STRONG, {16'($urandom), s});
    write_reg(REG_THR_STRONG_END, {16'($urandom), se});
    write_reg(REG_THR_ALERT, {16'($urandom), a});
  endtask

  task automatic random_config();
    logic [WW-1:0]    w;
    logic [THR_W-1:0] m;
    logic [THR_W-1:0] s;
    logic [THR_W-1:0] se;
    logic [THR_W-1:0] a;
    int               pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) w = '0;
    else if (pick == 1) w = WEIGHT_ONE;
    else if (pick == 2) w = WW'($urandom_range(257, 511));
    else w = WW'($urandom_range(1, 255));
    if ($urandom_range(0, 9) < 7) begin
      m  = THR_W'($urandom_range(0, 2000));
      s  = m + THR_W'($urandom_range(0, 3000));
      se = s + THR_W'($urandom_range(0, 6000));
      a  = se + THR_W'($urandom_range(0, 40000));
    end else begin
      m  = THR_W'($urandom);
      s  = THR_W'($urandom);
      se = THR_W'($urandom);
      a  = THR_W'($urandom);
    end
    load_config(w, m, s, se, a);
  endtask

  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] x,
                             input logic signed [SAMPLE_BITS-1:0] y);
    if (!steady && $urandom_range(0, 4) == 0) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.raw_x <= x;
    sample_ch.raw_y <= y;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
  endtask

  task automatic next_sample(output logic signed [SAMPLE_BITS-1:0] x,
                             output logic signed [SAMPLE_BITS-1:0] y);
    int pick;
    int span;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      span = (pick == 0) ? 300 : (pick < 3) ? 8 : 40;
      walk_x = walk_x + int'($urandom_range(0, 2 * span)) - span;
      walk_y = walk_y + int'($urandom_range(0, 2 * span)) - span;
      if (walk_x < -512) walk_x = -512;
      if (walk_x > 511) walk_x = 511;
      if (walk_y < -512) walk_y = -512;
      if (walk_y > 511) walk_y = 511;
      x = SAMPLE_BITS'(walk_x);
      y = SAMPLE_BITS'(walk_y);
    end else if (pick < 9) begin
      x = SAMPLE_BITS'($urandom);
      y = SAMPLE_BITS'($urandom);
    end else begin
      x = $urandom_range(0, 1) ? -10'sd512 : 10'sd511;
      y = $urandom_range(0, 1) ? -10'sd512 : 10'sd511;
    end
  endtask

  task automatic run_random(input int count);
    logic signed [SAMPLE_BITS-1:0] x;
    logic signed [SAMPLE_BITS-1:0] y;
    repeat (count) begin
      next_sample(x, y);
      send_sample(x, y);
    end
  endtask

  task automatic wait_drained();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (RESULT_LATENCY) @(posedge clk);
  endtask

  initial begin
    rst             <= 1'b1;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    sample_ch.valid <= 1'b0;
    sample_ch.raw_x <= '0;
    sample_ch.raw_y <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_sample(10'sd0, 10'sd0);
    send_sample(10'sd20, 10'sd0);
    send_sample(10'sd0, 10'sd0);
    send_sample(10'sd45, 10'sd0);
    send_sample(10'sd0, -10'sd45);
    send_sample(-10'sd100, 10'sd100);
    send_sample(10'sd511, 10'sd511);
    send_sample(-10'sd512, -10'sd512);
    send_sample(10'sd511, -10'sd512);
    send_sample(-10'sd512, 10'sd511);
    send_sample(10'sd511, 10'sd511);
    send_sample(10'sd0, 10'sd0);
    send_sample(-10'sd1, -10'sd1);
    run_random(90);
    wait_drained();
    run_random(40);

    wait_drained();
    load_config(WEIGHT_ONE, 16'd1000, 16'd5000, 16'd60000, 16'd65535);
    send_sample(-10'sd512, -10'sd512);
    send_sample(10'sd511, 10'sd511);
    send_sample(10'sd511, -10'sd512);
    send_sample(-10'sd512, 10'sd511);
    run_random(50);

    wait_drained();
    load_config('0, '0, '0, '0, '0);
    send_sample(10'sd511, -10'sd512);
    send_sample(10'sd0, 10'sd0);
    run_random(30);

    wait_drained();
    load_config(9'd511, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_sample(10'sd511, 10'sd511);
    send_sample(-10'sd512, -10'sd512);
    run_random(30);

    wait_drained();
    load_config(9'd128, 16'd3000, 16'd1000, 16'd500, 16'd2000);
    write_reg(REG_UNMAPPED, $urandom);
    run_random(40);

    repeat (5) begin
      wait_drained();
      random_config();
      run_random(40);
    end

    wait_drained();
    random_config();
    steady = 1'b1;
    run_random(40);

    wait_drained();
    repeat (4 * RESULT_LATENCY) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[lateral_tremor_detector_unit] OK");
    end else begin
      $display("[lateral_tremor_detector_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/ltd_pkg.sv
design/ltd_sample_if.sv
design/ltd_result_if.sv
design/ltd_cfg.sv
design/ltd_ctrl.sv
design/ltd_dp.sv
design/lateral_tremor_detector_unit.sv
design/ltd_checker.sv
test/ltd_tremor_checker.sv
test/tb_lateral_tremor_detector_unit.sv
